// ===== sv/qft_pkg.sv =====
package qft_pkg;

   localparam int unsigned MAX_SPACE_RUN_DEF = 255;
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_AW = $clog2(RSP_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SUB   = 8'h1A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   typedef enum logic [1:0] {
      SUB_LEAD = 2'd0,
      SUB_BODY = 2'd1,
      SUB_INQ  = 2'd2,
      SUB_DISC = 2'd3
   } sub_type;

   typedef enum logic [1:0] {
      GRP_FIXED = 2'd0,
      GRP_UNQ   = 2'd1,
      GRP_LF    = 2'd2,
      GRP_LFCR  = 2'd3
   } grp_type;

   typedef enum logic [3:0] {
      MODE_IDLE      = 4'd0,
      MODE_QIN       = 4'd1,
      MODE_QCLOSED   = 4'd2,
      MODE_AFTER_CR  = 4'd3,
      MODE_UNQ_LEAD  = 4'd4,
      MODE_UNQ_BODY  = 4'd5,
      MODE_UNQ_INQ   = 4'd6,
      MODE_UNQ_DISC  = 4'd7,
      MODE_LF_LEAD   = 4'd8,
      MODE_LF_BODY   = 4'd9,
      MODE_LF_INQ    = 4'd10,
      MODE_LF_DISC   = 4'd11,
      MODE_LFCR_LEAD = 4'd12,
      MODE_LFCR_BODY = 4'd13,
      MODE_LFCR_INQ  = 4'd14,
      MODE_LFCR_DISC = 4'd15
   } mode_type;

   typedef struct packed {
      logic [7:0] space_count;
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_end;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last_of_run;
   } rsp_entry_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  rslt0;
      token_type  rslt1;
   } step_out_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] held;
      logic       emit;
      token_type  rslt;
   } step_res_type;

   localparam token_type CLOSE_TOKEN = '{space_count: 8'd0, token_byte: 8'd0,
                                         byte_valid: 1'b0, token_end: 1'b1};

   function automatic mode_type mode_of(grp_type grp, sub_type s);
      return mode_type'({grp, s});
   endfunction

   function automatic token_type byte_token(logic [7:0] sp, logic [7:0] b);
      token_type t;
      t.space_count = sp;
      t.token_byte  = b;
      t.byte_valid  = 1'b1;
      t.token_end   = 1'b0;
      return t;
   endfunction

   function automatic step_res_type content_step(logic [7:0] b, sub_type s, mode_type mode,
                                                 logic [7:0] held, logic [7:0] lim);
      step_res_type res;
      res.mode = mode;
      res.held = held;
      res.emit = 1'b0;
      res.rslt = '0;
      case (s)
         SUB_LEAD: begin
            if (b == CH_QUOTE) begin
               res.mode = MODE_UNQ_INQ;
            end else if (b != CH_SPACE && b != CH_TAB) begin
               res.emit = 1'b1;
               res.rslt = byte_token(8'd0, b);
               res.mode = MODE_UNQ_BODY;
            end
         end
         SUB_BODY: begin
            if (b == CH_SPACE) begin
               if (held < lim) begin
                  res.held = held + 8'd1;
               end
            end else begin
               res.emit = 1'b1;
               res.rslt = byte_token(held, b);
               res.held = 8'd0;
            end
         end
         SUB_INQ: begin
            if (b == CH_QUOTE) begin
               res.mode = MODE_UNQ_DISC;
            end else begin
               res.emit = 1'b1;
               res.rslt = byte_token(8'd0, b);
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic step_res_type unq_step(logic [7:0] b, sub_type s, logic [7:0] held,
                                             logic [7:0] lim);
      step_res_type res;
      res.mode = mode_of(GRP_UNQ, s);
      res.held = held;
      res.emit = 1'b0;
      res.rslt = '0;
      if (b == CH_CR) begin
         res.emit = 1'b1;
         res.rslt = CLOSE_TOKEN;
         res.held = 8'd0;
         res.mode = MODE_AFTER_CR;
      end else if (b == CH_LF) begin
         res.mode = mode_of(GRP_LF, s);
      end else if (b == CH_COMMA) begin
         res.emit = 1'b1;
         res.rslt = CLOSE_TOKEN;
         res.held = 8'd0;
         res.mode = MODE_IDLE;
      end else if (b != CH_NUL) begin
         res = content_step(b, s, res.mode, held, lim);
      end
      return res;
   endfunction

   function automatic step_res_type idle_step(logic [7:0] b, logic [7:0] held,
                                              logic [7:0] lim);
      step_res_type res;
      res.mode = MODE_IDLE;
      res.held = held;
      res.emit = 1'b0;
      res.rslt = '0;
      if (b == CH_QUOTE) begin
         res.mode = MODE_QIN;
      end else if (b != CH_SPACE) begin
         res = unq_step(b, SUB_LEAD, held, lim);
      end
      return res;
   endfunction

endpackage

// ===== sv/qft_parser.sv =====
module qft_parser #(
   parameter int unsigned MAX_SPACE_RUN = qft_pkg::MAX_SPACE_RUN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_data,
   output qft_pkg::step_out_type step_out
);

   localparam logic [7:0] SPACE_LIMIT = (MAX_SPACE_RUN < 255) ? 8'(MAX_SPACE_RUN) : 8'd255;

   qft_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        held_ff, held_in;
   logic              ended_ff, ended_in;

   qft_pkg::mode_type    nx_mode;
   logic [7:0]           nx_held;
   logic                 nx_ended;
   qft_pkg::step_out_type nx_out;

   always_comb begin
      qft_pkg::step_res_type t;
      qft_pkg::sub_type      s;
      s        = qft_pkg::sub_type'(mode_ff[1:0]);
      t        = '0;
      nx_mode  = mode_ff;
      nx_held  = held_ff;
      nx_ended = ended_ff;
      nx_out   = '0;
      if (ended_ff) begin
         nx_out.count = 2'd0;
      end else if (end_of_data || data_byte == qft_pkg::CH_SUB) begin
         nx_ended = 1'b1;
         nx_mode  = qft_pkg::MODE_IDLE;
         nx_held  = 8'd0;
         if (mode_ff[3:2] == 2'b10) begin
            t = qft_pkg::content_step(qft_pkg::CH_SUB, s, mode_ff, held_ff, SPACE_LIMIT);
            if (t.emit) begin
               nx_out.rslt0 = t.rslt;
               nx_out.rslt1 = qft_pkg::CLOSE_TOKEN;
               nx_out.count = 2'd2;
            end else begin
               nx_out.rslt0 = qft_pkg::CLOSE_TOKEN;
               nx_out.count = 2'd1;
            end
         end else if (mode_ff != qft_pkg::MODE_IDLE && mode_ff != qft_pkg::MODE_AFTER_CR) begin
            nx_out.rslt0 = qft_pkg::CLOSE_TOKEN;
            nx_out.count = 2'd1;
         end
      end else begin
         case (mode_ff) inside
            qft_pkg::MODE_IDLE: begin
               t = qft_pkg::idle_step(data_byte, held_ff, SPACE_LIMIT);
            end
            qft_pkg::MODE_QIN: begin
               t.mode = mode_ff;
               t.held = held_ff;
               if (data_byte == qft_pkg::CH_QUOTE) begin
                  t.mode = qft_pkg::MODE_QCLOSED;
               end else if (data_byte != qft_pkg::CH_NUL) begin
                  t.emit = 1'b1;
                  t.rslt = qft_pkg::byte_token(8'd0, data_byte);
               end
            end
            qft_pkg::MODE_QCLOSED: begin
               t.mode = mode_ff;
               t.held = held_ff;
               if (data_byte != qft_pkg::CH_SPACE) begin
                  nx_out.rslt0 = qft_pkg::CLOSE_TOKEN;
                  nx_out.count = 2'd1;
                  t.held = 8'd0;
                  if (data_byte == qft_pkg::CH_CR) begin
                     t.mode = qft_pkg::MODE_AFTER_CR;
                  end else if (data_byte == qft_pkg::CH_COMMA) begin
                     t.mode = qft_pkg::MODE_IDLE;
                  end else begin
                     t = qft_pkg::idle_step(data_byte, 8'd0, SPACE_LIMIT);
                  end
               end
            end
            qft_pkg::MODE_AFTER_CR: begin
               if (data_byte == qft_pkg::CH_LF) begin
                  t.mode = qft_pkg::MODE_IDLE;
                  t.held = held_ff;
               end else begin
                  t = qft_pkg::idle_step(data_byte, held_ff, SPACE_LIMIT);
               end
            end
            [qft_pkg::MODE_LF_LEAD:qft_pkg::MODE_LF_DISC]: begin
               t.mode = mode_ff;
               t.held = held_ff;
               if (data_byte == qft_pkg::CH_CR) begin
                  t.mode = qft_pkg::mode_of(qft_pkg::GRP_LFCR, s);
               end else if (data_byte != qft_pkg::CH_LF) begin
                  t = qft_pkg::unq_step(data_byte, s, held_ff, SPACE_LIMIT);
               end
            end
            default: begin
               t = qft_pkg::unq_step(data_byte, s, held_ff, SPACE_LIMIT);
            end
         endcase
         nx_mode = t.mode;
         nx_held = t.held;
         if (t.emit) begin
            if (nx_out.count == 2'd0) begin
               nx_out.rslt0 = t.rslt;
               nx_out.count = 2'd1;
            end else begin
               nx_out.rslt1 = t.rslt;
               nx_out.count = 2'd2;
            end
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      held_in  = held_ff;
      ended_in = ended_ff;
      if (fire) begin
         mode_in  = nx_mode;
         held_in  = nx_held;
         ended_in = nx_ended;
      end
   end

   always_comb begin
      step_out = nx_out;
      if (!fire) begin
         step_out.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qft_pkg::MODE_IDLE;
         held_ff  <= 8'd0;
         ended_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         ended_ff <= ended_in;
      end
   end

endmodule

// ===== sv/qft_rsp_queue.sv =====
module qft_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  qft_pkg::step_out_type step_out,
   output logic                  can_push,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output qft_pkg::rsp_entry_type rsp_entry
);

   localparam int unsigned CW = qft_pkg::RSP_AW + 1;

   qft_pkg::rsp_entry_type entry_ff [qft_pkg::RSP_DEPTH];
   logic [qft_pkg::RSP_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [qft_pkg::RSP_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       pop;
   logic [qft_pkg::RSP_AW-1:0] wr_next;

   assign can_push  = count_ff <= CW'(qft_pkg::RSP_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_entry = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + qft_pkg::RSP_AW'(step_out.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(step_out.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (step_out.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= '{tok: step_out.rslt0,
                                  last_of_run: (step_out.count == 2'd1)};
      end
      if (step_out.count == 2'd2) begin
         entry_ff[wr_next] <= '{tok: step_out.rslt1, last_of_run: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/quoted_field_tokenizer.sv =====
// Channel  Direction  Ports                                          Accepted when
// req      in         req_valid, req_stall, req_data_byte,           req_valid && !req_stall
//                     req_end_of_data
// rsp      out        rsp_valid, rsp_stall, rsp_space_count,         rsp_valid && !rsp_stall
//                     rsp_token_byte, rsp_byte_valid, rsp_token_end,
//                     rsp_last_of_run
//
// A transaction is registered on acceptance and parsed once the queue has room, so a new
// byte can be taken every cycle unless stalled. Its zero to two results enter a four-entry
// result queue and leave at one per cycle unless stalled, which sets the sustained rate when
// bytes produce two results each. Reset is synchronous and returns the parser to the start
// of a stream. The input stalls only while the queue has fewer than two free entries.
module quoted_field_tokenizer #(
   parameter int unsigned MAX_SPACE_RUN = qft_pkg::MAX_SPACE_RUN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_space_count,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_token_end,
   output logic       rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eod_ff, in_eod_in;
   logic       can_push;
   logic       fire;

   qft_pkg::step_out_type  step_out;
   qft_pkg::rsp_entry_type rsp_entry;

   assign fire      = in_valid_ff && can_push;
   assign req_stall = in_valid_ff && !can_push;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eod_in   = in_eod_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
         in_eod_in   = req_end_of_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_eod_ff  <= in_eod_in;
   end

   qft_parser #(
      .MAX_SPACE_RUN(MAX_SPACE_RUN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .end_of_data(in_eod_ff),
      .step_out   (step_out)
   );

   qft_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .step_out (step_out),
      .can_push (can_push),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry(rsp_entry)
   );

   assign rsp_space_count = rsp_entry.tok.space_count;
   assign rsp_token_byte  = rsp_entry.tok.token_byte;
   assign rsp_byte_valid  = rsp_entry.tok.byte_valid;
   assign rsp_token_end   = rsp_entry.tok.token_end;
   assign rsp_last_of_run = rsp_entry.last_of_run;

endmodule
